// ===== rtl/psbs_pkg.sv =====
// Package: request/response types, mode codes and the slot operation for the packed slot store.
`default_nettype none
package psbs_pkg;

    localparam int ENTRY_W = 12;
    localparam int WORD_W  = 16;

    localparam logic [2:0] MODE_READ      = 3'd0;
    localparam logic [2:0] MODE_TEST      = 3'd1;
    localparam logic [2:0] MODE_CLEAR     = 3'd2;
    localparam logic [2:0] MODE_TRY_SET   = 3'd3;
    localparam logic [2:0] MODE_TRY_CLEAR = 3'd4;
    localparam logic [2:0] MODE_INC       = 3'd5;
    localparam logic [2:0] MODE_DEC       = 3'd6;

    typedef struct packed {
        logic [2:0]         mode;
        logic [ENTRY_W-1:0] entry;
        logic [2:0]         bit_sel;
    } req_t;

    typedef struct packed {
        logic [2:0] value;
        logic       flag;
    } rsp_t;

    typedef struct packed {
        logic [WORD_W-1:0] new_word;
        logic [2:0]        value;
        logic              flag;
    } op_res_t;

    // One read-modify-write step on the word holding the slot.
    function automatic op_res_t apply_op(
        input logic [2:0]        mode,
        input logic [WORD_W-1:0] old,
        input logic [3:0]        rest,
        input logic [2:0]        bit_sel,
        input logic [1:0]        sl
    );
        op_res_t           r;
        logic [4:0]        bpos;
        logic [WORD_W-1:0] bmask;
        logic [WORD_W-1:0] step;
        logic [WORD_W-1:0] shifted;
        logic [2:0]        vmask;
        bpos    = {1'b0, rest} + {2'b00, bit_sel};
        bmask   = bpos[4] ? '0 : (16'd1 << bpos[3:0]);
        step    = 16'd1 << rest;
        vmask   = 3'((4'd1 << sl) - 4'd1);
        shifted = '0;
        r.new_word = old;
        r.value    = '0;
        r.flag     = 1'b0;
        unique case (mode)
            MODE_READ: begin
                shifted = old >> rest;
                r.value = shifted[2:0] & vmask;
            end
            MODE_TEST: begin
                r.flag = |(old & bmask);
            end
            MODE_CLEAR: begin
                r.new_word = old & ~bmask;
            end
            MODE_TRY_SET: begin
                r.new_word = old | bmask;
                r.flag     = ~|(old & bmask);
            end
            MODE_TRY_CLEAR: begin
                r.new_word = old & ~bmask;
                r.flag     = |(old & bmask);
            end
            MODE_INC: begin
                r.new_word = old + step;
                shifted    = r.new_word >> rest;
                r.value    = shifted[2:0] & vmask;
            end
            MODE_DEC: begin
                r.new_word = old - step;
                shifted    = r.new_word >> rest;
                r.value    = shifted[2:0] & vmask;
            end
            default: begin
                r.new_word = old;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/psbs_word_ram.sv =====
// Simple dual-port word memory: one write port, one registered read port.
`default_nettype none
module psbs_word_ram #(
    parameter int ADDR_W = 11
) (
    input  wire logic                          aclk,
    input  wire logic                          we,
    input  wire logic [ADDR_W-1:0]             waddr,
    input  wire logic [psbs_pkg::WORD_W-1:0]   wdata,
    input  wire logic                          re,
    input  wire logic [ADDR_W-1:0]             raddr,
    output logic      [psbs_pkg::WORD_W-1:0]   rdata
);

    logic [psbs_pkg::WORD_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read-old on a same-cycle collision; rdata holds between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/packed_slot_bit_store_top.sv =====
// Top level of the packed slot bit store: request pipeline, forwarding and clear sweep.
//
//  channel   dir  handshake             payload
//  s_        in   s_valid / s_ready     psbs_pkg::req_t   (mode, entry, bit_sel)
//  m_        out  m_valid / m_ready     psbs_pkg::rsp_t   (value, flag)
//  cfg_      in   cfg_valid / cfg_ready cfg_data = slot_log (2 bits)
//
// Cycles: one request per cycle sustained while m_ready stays high. The word is read
//   from memory at the accept edge into the stage, and written back when the staged
//   request advances, as the result enters the output register and m_valid rises.
// Reset: after aresetn the memory is swept to zero, one word a cycle, for
//   2**(ENTRY_INDEX_BITS-1) cycles; s_ready stays low meanwhile (cfg writes still taken).
// Stalls: with m_ready low the output register and one staged request hold;
//   s_ready drops only when both are full.
`default_nettype none
module packed_slot_bit_store_top #(
    parameter int ENTRY_INDEX_BITS = 12
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire psbs_pkg::req_t   s_payload,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output psbs_pkg::rsp_t        m_payload,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_data
);

    // word address width: one 16-bit word holds 2**(4-slot_log) entries
    localparam int AW = ENTRY_INDEX_BITS - 1;
    localparam int EW = psbs_pkg::ENTRY_W;
    localparam logic [EW-1:0] ENTRY_MASK = (ENTRY_INDEX_BITS >= EW) ? '1 :
        EW'((32'd1 << ENTRY_INDEX_BITS) - 32'd1);

    // configuration
    logic [1:0] slot_log_reg;

    // clear sweep
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;

    // staged request (word already being read)
    logic          st_vld_reg;
    logic [2:0]    st_mode_reg;
    logic [2:0]    st_bit_reg;
    logic [3:0]    st_rest_reg;
    logic [AW-1:0] st_addr_reg;

    // last write-back, forwarded to a request whose read hit the same edge
    logic                        wr_vld_reg;
    logic [AW-1:0]               wr_addr_reg;
    logic [psbs_pkg::WORD_W-1:0] wr_data_reg;

    // output register
    logic           m_valid_reg;
    psbs_pkg::rsp_t m_payload_reg;

    logic                        adv;
    logic                        accept;
    logic [EW-1:0]               entry_m;
    logic [EW+2:0]               bit_addr;
    logic [EW-2:0]               word_idx;
    logic [AW-1:0]               req_addr;
    logic [psbs_pkg::WORD_W-1:0] rdata;
    logic [psbs_pkg::WORD_W-1:0] old_word;
    psbs_pkg::op_res_t           res;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [psbs_pkg::WORD_W-1:0] ram_wdata;

    assign cfg_ready = 1'b1;

    assign adv     = st_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clearing_reg && (!st_vld_reg || adv);
    assign accept  = s_valid && s_ready;

    // slot bit address = entry << slot_log; word index is its upper part
    assign entry_m  = s_payload.entry & ENTRY_MASK;
    assign bit_addr = {3'b000, entry_m} << slot_log_reg;
    assign word_idx = bit_addr[EW+2:4];
    assign req_addr = AW'(word_idx);

    assign old_word = (wr_vld_reg && (wr_addr_reg == st_addr_reg)) ? wr_data_reg : rdata;
    assign res = psbs_pkg::apply_op(st_mode_reg, old_word, st_rest_reg, st_bit_reg,
                                    slot_log_reg);

    assign ram_we    = clearing_reg || adv;
    assign ram_waddr = clearing_reg ? clr_addr_reg : st_addr_reg;
    assign ram_wdata = clearing_reg ? '0 : res.new_word;

    psbs_word_ram #(
        .ADDR_W (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (req_addr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_log_reg <= 2'd1;
        end else if (cfg_valid && cfg_ready) begin
            slot_log_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // request stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg <= 1'b0;
        end else if (accept) begin
            st_vld_reg <= 1'b1;
        end else if (adv) begin
            st_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_mode_reg <= s_payload.mode;
            st_bit_reg  <= s_payload.bit_sel;
            st_rest_reg <= bit_addr[3:0];
            st_addr_reg <= req_addr;
        end
    end

    // forwarding register: the sweep writes zeros, so it just invalidates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_vld_reg <= 1'b0;
        end else if (clearing_reg) begin
            wr_vld_reg <= 1'b0;
        end else if (adv) begin
            wr_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wr_addr_reg <= st_addr_reg;
            wr_data_reg <= res.new_word;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_payload_reg.value <= res.value;
            m_payload_reg.flag  <= res.flag;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTHESIS
    // no request slips in while the memory is still being swept
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !(s_valid && s_ready))
        else $error("request accepted during clear sweep");

    // an accepted request always lands in the stage
    a_accept_stages: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> st_vld_reg)
        else $error("accepted request not staged");

    // full stage and blocked output must back-pressure the input
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_vld_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input ready while pipeline is full");

    // sweep ends only after the last word
    a_sweep_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clearing_reg) |-> ($past(clr_addr_reg) == {AW{1'b1}}))
        else $error("clear sweep ended early");
`endif

endmodule
`default_nettype wire
